// ===== hw/rtl/dcm_rk4_pkg.sv =====
package dcm_rk4_pkg;

    localparam int FRAC_BITS = 16;

    // Ceiling of 2^34 / 6, used to divide a magnitude below 2^34 by six.
    localparam logic [31:0] RECIP6 = 32'd2863311531;

    typedef enum logic [2:0] {
        CFG_RESISTANCE  = 3'd0,
        CFG_BACK_EMF    = 3'd1,
        CFG_TORQUE      = 3'd2,
        CFG_FRICTION    = 3'd3,
        CFG_INV_IND     = 3'd4,
        CFG_INV_INERTIA = 3'd5,
        CFG_TIME_STEP   = 3'd6
    } t_cfg_index;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RATE,
        ST_INC,
        ST_WRITE
    } t_state;

    typedef enum logic [1:0] {
        VAR_CURRENT  = 2'd0,
        VAR_VELOCITY = 2'd1,
        VAR_POSITION = 2'd2
    } t_var;

    typedef struct packed {
        logic               op;
        logic signed [31:0] drive_voltage;
        logic signed [31:0] load_torque_in;
        logic signed [31:0] load_current;
        logic signed [31:0] load_velocity;
        logic signed [47:0] load_position;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] current_out;
        logic signed [31:0] velocity_out;
        logic signed [47:0] position_out;
    } t_out_item;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
        logic signed [31:0] res;
        if (x > 64'sd2147483647) begin
            res = 32'sh7FFFFFFF;
        end else if (x < -64'sd2147483648) begin
            res = 32'sh80000000;
        end else begin
            res = x[31:0];
        end
        return res;
    endfunction

endpackage

// ===== hw/rtl/dc_motor_rk4_plant_model.sv =====
// DC motor plant for hardware-in-the-loop use, one fourth-order Runge-Kutta step per item.
// Input channel: i_in_valid, o_in_stall, i_in_data. A transfer takes place when valid
// is high and stall is low. An item with op 0 integrates one step with the given
// voltage and load torque; an item with op 1 loads current, velocity and position.
// Output channel: o_out_valid, i_out_stall, o_out_data carrying the state after the item.
// Configuration channel: i_cfg_valid, o_cfg_ready, i_cfg_index, i_cfg_data; ready is
// always high, and an index beyond the register list is ignored.
// A step item passes through four derivative stages, three increments and the write
// state, all through one shared 36 by 33 bit multiplier with a registered product.
// A new item is taken only in the idle state, once the last one has left the write
// state. A load item goes from its transfer straight to the write state, and the
// next item can be taken once the write state has returned to idle.
// The input stalls for the whole computation.
// The result sits in an output register; the next item may be taken while it waits,
// and a finished result waits in the write state until the output register is free.
// Reset clears the state to zero and the registers to their defaults.
module dc_motor_rk4_plant_model (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  dcm_rk4_pkg::t_in_item   i_in_data,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output dcm_rk4_pkg::t_out_item  o_out_data,
    input  logic                    i_cfg_valid,
    output logic                    o_cfg_ready,
    input  logic [2:0]              i_cfg_index,
    input  logic [31:0]             i_cfg_data
);

    dcm_rk4_pkg::t_state r_state, n_state;
    logic [3:0]  r_sub, n_sub;
    logic [1:0]  r_stg, n_stg;
    logic [1:0]  r_var, n_var;

    logic [31:0] r_res, r_ke, r_kt, r_fric, r_invl, r_invj, r_h;
    logic signed [31:0] r_i, r_w;
    logic signed [47:0] r_p;
    logic signed [31:0] r_v, r_tl, r_si, r_sw, r_di, r_dw;
    logic signed [59:0] r_acc_e, r_acc_m;
    logic signed [35:0] r_s_i, r_s_w, r_s_p;
    logic signed [68:0] r_prod;
    logic signed [35:0] r_n, r_q;
    logic        r_neg;
    logic        r_out_valid;
    dcm_rk4_pkg::t_out_item r_out;

    logic signed [35:0] mul_a;
    logic [31:0]        mul_b;
    logic signed [59:0] q_prod;
    logic signed [31:0] sat_e, sat_m;
    logic               wt2;
    logic [5:0]         stg_sh;
    logic signed [36:0] t_val;
    logic signed [37:0] diff;
    logic signed [35:0] q_fix;
    logic signed [36:0] inc;
    logic               out_free;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != dcm_rk4_pkg::ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign out_free    = !r_out_valid || !i_out_stall;

    assign q_prod = 60'(r_prod >>> dcm_rk4_pkg::FRAC_BITS);
    assign sat_e  = dcm_rk4_pkg::sat32(64'(r_acc_e));
    assign sat_m  = dcm_rk4_pkg::sat32(64'(r_acc_m));
    assign wt2    = (r_stg == 2'd1) || (r_stg == 2'd2);
    assign stg_sh = (r_stg == 2'd2) ? 6'd32 : 6'd33;
    assign t_val  = 37'(r_prod >>> 32);
    assign diff   = 38'(r_n) - (38'(r_q) <<< 2) - (38'(r_q) <<< 1);
    assign q_fix  = (diff < 0) ? (r_q - 36'sd1) : r_q;
    assign inc    = r_neg ? -37'(q_fix) : 37'(q_fix);

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        if (r_state == dcm_rk4_pkg::ST_RATE) begin
            case (r_sub)
                4'd0: begin mul_a = 36'(r_si);  mul_b = r_res;  end
                4'd1: begin mul_a = 36'(r_sw);  mul_b = r_ke;   end
                4'd2: begin mul_a = 36'(r_si);  mul_b = r_kt;   end
                4'd3: begin mul_a = 36'(r_sw);  mul_b = r_fric; end
                4'd4: begin mul_a = 36'(sat_e); mul_b = r_invl; end
                4'd5: begin mul_a = 36'(sat_m); mul_b = r_invj; end
                4'd6: begin mul_a = 36'(r_di);  mul_b = r_h;    end
                4'd7: begin mul_a = 36'(r_dw);  mul_b = r_h;    end
                default: begin mul_a = '0; mul_b = '0; end
            endcase
        end else if (r_state == dcm_rk4_pkg::ST_INC) begin
            if (r_sub == 4'd0) begin
                mul_b = r_h;
                case (r_var)
                    dcm_rk4_pkg::VAR_CURRENT:  mul_a = r_s_i;
                    dcm_rk4_pkg::VAR_VELOCITY: mul_a = r_s_w;
                    default:                   mul_a = r_s_p;
                endcase
            end else if (r_sub == 4'd2) begin
                mul_a = r_n;
                mul_b = dcm_rk4_pkg::RECIP6;
            end
        end
    end

    always_comb begin
        n_state = r_state;
        n_sub   = r_sub;
        n_stg   = r_stg;
        n_var   = r_var;
        case (r_state)
            dcm_rk4_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_sub = '0;
                    n_stg = '0;
                    n_state = i_in_data.op ? dcm_rk4_pkg::ST_WRITE : dcm_rk4_pkg::ST_RATE;
                end
            end
            dcm_rk4_pkg::ST_RATE: begin
                n_sub = r_sub + 4'd1;
                if (r_sub == 4'd7 && r_stg == 2'd3) begin
                    n_state = dcm_rk4_pkg::ST_INC;
                    n_sub   = '0;
                    n_var   = dcm_rk4_pkg::VAR_CURRENT;
                end else if (r_sub == 4'd8) begin
                    n_sub = '0;
                    n_stg = r_stg + 2'd1;
                end
            end
            dcm_rk4_pkg::ST_INC: begin
                n_sub = r_sub + 4'd1;
                if (r_sub == 4'd4) begin
                    n_sub = '0;
                    if (r_var == dcm_rk4_pkg::VAR_POSITION) begin
                        n_state = dcm_rk4_pkg::ST_WRITE;
                    end else begin
                        n_var = r_var + 2'd1;
                    end
                end
            end
            dcm_rk4_pkg::ST_WRITE: begin
                if (out_free) begin
                    n_state = dcm_rk4_pkg::ST_IDLE;
                end
            end
            default: n_state = dcm_rk4_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dcm_rk4_pkg::ST_IDLE;
            r_sub   <= '0;
            r_stg   <= '0;
            r_var   <= '0;
        end else begin
            r_state <= n_state;
            r_sub   <= n_sub;
            r_stg   <= n_stg;
            r_var   <= n_var;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res  <= 32'd65536;
            r_ke   <= 32'd65536;
            r_kt   <= 32'd65536;
            r_fric <= 32'd0;
            r_invl <= 32'd65536;
            r_invj <= 32'd65536;
            r_h    <= 32'd4294967;
        end else if (i_cfg_valid) begin
            case (dcm_rk4_pkg::t_cfg_index'(i_cfg_index))
                dcm_rk4_pkg::CFG_RESISTANCE:  r_res  <= i_cfg_data;
                dcm_rk4_pkg::CFG_BACK_EMF:    r_ke   <= i_cfg_data;
                dcm_rk4_pkg::CFG_TORQUE:      r_kt   <= i_cfg_data;
                dcm_rk4_pkg::CFG_FRICTION:    r_fric <= i_cfg_data;
                dcm_rk4_pkg::CFG_INV_IND:     r_invl <= i_cfg_data;
                dcm_rk4_pkg::CFG_INV_INERTIA: r_invj <= i_cfg_data;
                dcm_rk4_pkg::CFG_TIME_STEP:   r_h    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * $signed({1'b0, mul_b});
        case (r_state)
            dcm_rk4_pkg::ST_IDLE: begin
                r_v   <= i_in_data.drive_voltage;
                r_tl  <= i_in_data.load_torque_in;
                r_si  <= r_i;
                r_sw  <= r_w;
                r_s_i <= '0;
                r_s_w <= '0;
                r_s_p <= '0;
            end
            dcm_rk4_pkg::ST_RATE: begin
                case (r_sub)
                    4'd1: r_acc_e <= 60'(r_v) - q_prod;
                    4'd2: r_acc_e <= r_acc_e - q_prod;
                    4'd3: r_acc_m <= q_prod;
                    4'd4: r_acc_m <= r_acc_m - q_prod - 60'(r_tl);
                    4'd5: r_di <= dcm_rk4_pkg::sat32(64'(q_prod));
                    4'd6: begin
                        r_dw  <= dcm_rk4_pkg::sat32(64'(q_prod));
                        r_s_i <= r_s_i + (wt2 ? (36'(r_di) <<< 1) : 36'(r_di));
                        r_s_p <= r_s_p + (wt2 ? (36'(r_sw) <<< 1) : 36'(r_sw));
                    end
                    4'd7: begin
                        r_s_w <= r_s_w + (wt2 ? (36'(r_dw) <<< 1) : 36'(r_dw));
                        r_si  <= dcm_rk4_pkg::sat32(64'(r_i) + 64'(r_prod >>> stg_sh));
                    end
                    4'd8: r_sw <= dcm_rk4_pkg::sat32(64'(r_w) + 64'(r_prod >>> stg_sh));
                    default: ;
                endcase
            end
            dcm_rk4_pkg::ST_INC: begin
                case (r_sub)
                    4'd1: begin
                        r_neg <= t_val[36];
                        r_n   <= t_val[36] ? 36'(-t_val) : 36'(t_val);
                    end
                    4'd3: r_q <= 36'(r_prod >>> 34);
                    default: ;
                endcase
            end
            default: ;
        endcase
        if (r_state == dcm_rk4_pkg::ST_WRITE && out_free) begin
            r_out.current_out  <= r_i;
            r_out.velocity_out <= r_w;
            r_out.position_out <= r_p;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_i <= '0;
            r_w <= '0;
            r_p <= '0;
        end else if (r_state == dcm_rk4_pkg::ST_IDLE && i_in_valid && i_in_data.op) begin
            r_i <= i_in_data.load_current;
            r_w <= i_in_data.load_velocity;
            r_p <= i_in_data.load_position;
        end else if (r_state == dcm_rk4_pkg::ST_INC && r_sub == 4'd4) begin
            case (r_var)
                dcm_rk4_pkg::VAR_CURRENT:  r_i <= dcm_rk4_pkg::sat32(64'(r_i) + 64'(inc));
                dcm_rk4_pkg::VAR_VELOCITY: r_w <= dcm_rk4_pkg::sat32(64'(r_w) + 64'(inc));
                default:                   r_p <= r_p + 48'(inc);
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == dcm_rk4_pkg::ST_WRITE && out_free) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

endmodule

// ===== hw/rtl/dcm_rk4_chk.sv =====
module dcm_rk4_chk (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    input  logic                    o_in_stall,
    input  logic                    o_out_valid,
    input  logic                    i_out_stall,
    input  dcm_rk4_pkg::t_out_item  o_out_data
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("Stalled result changed or vanished.");

    a_busy_after_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("Input not stalled after an item transfer.");

    a_result_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid ##1 o_out_valid |-> $past(o_in_stall))
        else $error("Result appeared without an item in progress.");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("Reset did not clear the channels.");

endmodule

bind dc_motor_rk4_plant_model dcm_rk4_chk u_dcm_rk4_chk (.*);
